// File: hdl/mes_pkg.sv
// Midpoint element search: shared constants, codes and control structs.
// Used by both interfaces and by every module of the block but mes_ram; depends on nothing.

package mes_pkg;

  localparam int MAX_ELEMS   = 32;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(MAX_ELEMS);
  localparam int LEN_W       = $clog2(MAX_ELEMS + 1);
  localparam int MID_W       = 5;
  localparam int COUNT_W     = 6;
  localparam int SUM_W       = DATA_W + 2;
  localparam int MAX_ENTRIES = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [1:0] {
    RSEL_I,
    RSEL_J,
    RSEL_K
  } mes_rsel_t;

  typedef struct packed {
    logic      load_wr;
    logic      i_clr;
    logic      i_inc;
    logic      ai_cap;
    logic      j_clr;
    logic      j_inc;
    logic      aj_cap;
    logic      k_set;
    logic      k_issue;
    logic      hit_cap;
    logic      emit_entry;
    logic      emit_total;
    logic      run_clr;
    mes_rsel_t rsel;
  } mes_cmd_t;

  typedef struct packed {
    logic i_done;
    logic j_end;
    logic j_eq_i;
    logic k_end;
    logic hit;
    logic cnt_lt_max;
    logic slot_free;
  } mes_sts_t;

endpackage

// File: hdl/mes_in_if.sv
// Input channel: one element per item, valid/ready handshake.
// Depends on mes_pkg.

interface mes_in_if import mes_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] elem_value;
  logic                     last_item;

  modport source (output valid, elem_value, last_item, input ready);
  modport sink   (input valid, elem_value, last_item, output ready);
endinterface

// File: hdl/mes_out_if.sv
// Result channel: match entries and the final total, valid/ready handshake.
// Depends on mes_pkg.

interface mes_out_if import mes_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic [MID_W-1:0]         mid_index;
  logic [MID_W-1:0]         pair_first;
  logic [MID_W-1:0]         pair_second;
  logic signed [DATA_W-1:0] mid_value;
  logic [COUNT_W-1:0]       match_count;
  logic                     overflow_flag;
  logic                     last_result;

  modport source (output valid, result_kind, mid_index, pair_first, pair_second,
                  mid_value, match_count, overflow_flag, last_result,
                  input ready);
  modport sink   (input valid, result_kind, mid_index, pair_first, pair_second,
                  mid_value, match_count, overflow_flag, last_result,
                  output ready);
endinterface

// File: hdl/midpoint_element_search.sv
// Elements are loaded one per item, one per cycle while the block is idle, into a 32-entry
// store; an item marked last starts the search, and the input stays stalled until the total
// result has been handed to the result register. The search over each i, each pair start j
// and each k scanned is paced by the single read port of the element store. Match entries
// leave in increasing i, then one total result. Elements beyond capacity are dropped and
// flagged on every result of that run.

module midpoint_element_search import mes_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mes_in_if.sink    in_ch,
  mes_out_if.source out_ch
);

  mes_cmd_t cmd;
  mes_sts_t sts;

  mes_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_last_item (in_ch.last_item),
    .in_ready     (in_ch.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mes_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_elem_value     (in_ch.elem_value),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_result_kind   (out_ch.result_kind),
    .out_mid_index     (out_ch.mid_index),
    .out_pair_first    (out_ch.pair_first),
    .out_pair_second   (out_ch.pair_second),
    .out_mid_value     (out_ch.mid_value),
    .out_match_count   (out_ch.match_count),
    .out_overflow_flag (out_ch.overflow_flag),
    .out_last_result   (out_ch.last_result)
  );

endmodule

// File: hdl/mes_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/mes_datapath.sv
// Datapath: element store, index counters, 34-bit pair compare, result register.
// Depends on mes_pkg and mes_ram; driven by mes_ctrl through mes_cmd_t.

module mes_datapath import mes_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mes_cmd_t                 cmd,
  output mes_sts_t                 sts,
  input  logic signed [DATA_W-1:0] in_elem_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_result_kind,
  output logic [MID_W-1:0]         out_mid_index,
  output logic [MID_W-1:0]         out_pair_first,
  output logic [MID_W-1:0]         out_pair_second,
  output logic signed [DATA_W-1:0] out_mid_value,
  output logic [COUNT_W-1:0]       out_match_count,
  output logic                     out_overflow_flag,
  output logic                     out_last_result
);

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               drop_r, drop_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   i_r, i_nxt;
  logic [LEN_W-1:0]   j_r, j_nxt;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic [LEN_W-1:0]   pk_r;
  logic               pvld_r, pvld_nxt;
  logic [LEN_W-1:0]   kh_r;
  logic [DATA_W-1:0]  ai_r;
  logic [DATA_W-1:0]  aj_r;

  logic               ov_r, ov_nxt;
  logic               okind_r;
  logic [MID_W-1:0]   omi_r, opj_r, opk_r;
  logic [DATA_W-1:0]  omv_r;
  logic [COUNT_W-1:0] ocnt_r;
  logic               oovf_r;

  logic               we;
  logic [IDX_W-1:0]   raddr;
  logic [DATA_W-1:0]  rdata;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   twice;
  logic               k_live;

  assign we = cmd.load_wr && (len_r < LEN_W'(MAX_ELEMS));

  always_comb begin
    case (cmd.rsel)
      RSEL_I:  raddr = i_r[IDX_W-1:0];
      RSEL_J:  raddr = j_r[IDX_W-1:0];
      default: raddr = k_r[IDX_W-1:0];
    endcase
  end

  mes_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (len_r[IDX_W-1:0]),
    .wdata (in_elem_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // exact sum of the pair against twice the midpoint candidate
  assign sum   = {{2{aj_r[DATA_W-1]}}, aj_r} + {{2{rdata[DATA_W-1]}}, rdata};
  assign twice = {ai_r[DATA_W-1], ai_r, 1'b0};
  assign k_live = (k_r < len_r) && (k_r != i_r);

  always_comb begin
    len_nxt  = len_r;
    drop_nxt = drop_r;
    cnt_nxt  = cnt_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    pvld_nxt = pvld_r;
    ov_nxt   = ov_r;

    if (cmd.load_wr) begin
      if (we) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
    if (cmd.i_clr) i_nxt = '0;
    if (cmd.i_inc) i_nxt = i_r + LEN_W'(1);
    if (cmd.j_clr) j_nxt = '0;
    if (cmd.j_inc) j_nxt = j_r + LEN_W'(1);
    if (cmd.k_set) begin
      k_nxt    = j_r + LEN_W'(1);
      pvld_nxt = 1'b0;
    end else if (cmd.k_issue) begin
      k_nxt    = k_r + LEN_W'(1);
      pvld_nxt = k_live;
    end
    if (cmd.hit_cap && (cnt_r != COUNT_MAX)) begin
      cnt_nxt = cnt_r + COUNT_W'(1);
    end
    if (cmd.run_clr) begin
      len_nxt  = '0;
      drop_nxt = 1'b0;
      cnt_nxt  = '0;
    end

    if (cmd.emit_entry || cmd.emit_total) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      drop_r <= 1'b0;
      cnt_r  <= '0;
      pvld_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      drop_r <= drop_nxt;
      cnt_r  <= cnt_nxt;
      pvld_r <= pvld_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    if (cmd.k_issue) pk_r <= k_r;
    if (cmd.hit_cap) kh_r <= pk_r;
    if (cmd.ai_cap)  ai_r <= rdata;
    if (cmd.aj_cap)  aj_r <= rdata;
    if (cmd.emit_entry) begin
      okind_r <= KIND_ENTRY;
      omi_r   <= MID_W'(i_r);
      opj_r   <= MID_W'(j_r);
      opk_r   <= MID_W'(kh_r);
      omv_r   <= ai_r;
      ocnt_r  <= '0;
      oovf_r  <= drop_r;
    end else if (cmd.emit_total) begin
      okind_r <= KIND_TOTAL;
      omi_r   <= '0;
      opj_r   <= '0;
      opk_r   <= '0;
      omv_r   <= '0;
      ocnt_r  <= cnt_r;
      oovf_r  <= drop_r;
    end
  end

  assign sts.i_done     = (i_r >= len_r);
  assign sts.j_end      = ((j_r + LEN_W'(1)) >= len_r);
  assign sts.j_eq_i     = (j_r == i_r);
  assign sts.k_end      = (k_r >= len_r);
  assign sts.hit        = pvld_r && (sum == twice);
  assign sts.cnt_lt_max = (cnt_r < COUNT_W'(MAX_ENTRIES));
  assign sts.slot_free  = !ov_r || out_ready;

  assign out_valid         = ov_r;
  assign out_result_kind   = okind_r;
  assign out_mid_index     = omi_r;
  assign out_pair_first    = opj_r;
  assign out_pair_second   = opk_r;
  assign out_mid_value     = omv_r;
  assign out_match_count   = ocnt_r;
  assign out_overflow_flag = oovf_r;
  assign out_last_result   = (okind_r == KIND_TOTAL);

endmodule

// File: hdl/mes_ctrl.sv
// Controller: load phase and the i/j/k search sequence.
// Depends on mes_pkg; drives mes_datapath through mes_cmd_t.

module mes_ctrl import mes_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_item,
  output logic     in_ready,
  input  mes_sts_t sts,
  output mes_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_I_START = 3'd1;
  localparam logic [2:0] ST_I_WAIT  = 3'd2;
  localparam logic [2:0] ST_J_START = 3'd3;
  localparam logic [2:0] ST_J_WAIT  = 3'd4;
  localparam logic [2:0] ST_K_SCAN  = 3'd5;
  localparam logic [2:0] ST_EMIT    = 3'd6;
  localparam logic [2:0] ST_TOTAL   = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsel  = RSEL_K;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (in_last_item) begin
            cmd.i_clr = 1'b1;
            state_nxt = ST_I_START;
          end
        end
      end
      ST_I_START: begin
        cmd.rsel = RSEL_I;
        state_nxt = sts.i_done ? ST_TOTAL : ST_I_WAIT;
      end
      ST_I_WAIT: begin
        cmd.ai_cap = 1'b1;
        cmd.j_clr  = 1'b1;
        state_nxt  = ST_J_START;
      end
      ST_J_START: begin
        cmd.rsel = RSEL_J;
        if (sts.j_end) begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_I_START;
        end else if (sts.j_eq_i) begin
          cmd.j_inc = 1'b1;
        end else begin
          state_nxt = ST_J_WAIT;
        end
      end
      ST_J_WAIT: begin
        cmd.aj_cap = 1'b1;
        cmd.k_set  = 1'b1;
        state_nxt  = ST_K_SCAN;
      end
      ST_K_SCAN: begin
        cmd.k_issue = !sts.k_end;
        if (sts.hit) begin
          cmd.hit_cap = 1'b1;
          if (sts.cnt_lt_max) begin
            state_nxt = ST_EMIT;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = ST_I_START;
          end
        end else if (sts.k_end) begin
          cmd.j_inc = 1'b1;
          state_nxt = ST_J_START;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit_entry = 1'b1;
          cmd.i_inc      = 1'b1;
          state_nxt      = ST_I_START;
        end
      end
      ST_TOTAL: begin
        if (sts.slot_free) begin
          cmd.emit_total = 1'b1;
          cmd.run_clr    = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/mes_checker.sv
// Port-level checks for midpoint_element_search, attached by bind.
// Depends on mes_pkg.

module mes_checker import mes_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last_item,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_result_kind,
  input logic [MID_W-1:0]   out_mid_index,
  input logic [MID_W-1:0]   out_pair_first,
  input logic [MID_W-1:0]   out_pair_second,
  input logic [DATA_W-1:0]  out_mid_value,
  input logic [COUNT_W-1:0] out_match_count,
  input logic               out_last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_mid_index) && $stable(out_mid_value) && $stable(out_match_count))
    else $error("result item changed while stalled");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_item |=> !in_ready)
    else $error("input accepted while search should be running");

  a_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ENTRY) |-> !in_ready)
    else $error("match entry pending while input is open");

  a_entry_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ENTRY) |->
      (out_pair_first < out_pair_second) && (out_match_count == '0) && !out_last_result)
    else $error("malformed match entry");

endmodule

bind midpoint_element_search mes_checker u_mes_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_last_item    (in_ch.last_item),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_kind (out_ch.result_kind),
  .out_mid_index   (out_ch.mid_index),
  .out_pair_first  (out_ch.pair_first),
  .out_pair_second (out_ch.pair_second),
  .out_mid_value   (out_ch.mid_value),
  .out_match_count (out_ch.match_count),
  .out_last_result (out_ch.last_result)
);

// File: tb/sv/midpoint_search_checker.sv
// Result checker for midpoint_element_search: watches both channels, predicts the results of
// every run of accepted elements and compares each result with the oldest prediction.
// Depends on mes_pkg, mes_in_if and mes_out_if.

module midpoint_search_checker import mes_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mes_in_if    in_mon,
  mes_out_if   out_mon,
  output int   fail_count,
  output int   outstanding,
  output int   results_checked,
  output int   entries_checked
);

  typedef struct packed {
    logic                     kind;
    logic [MID_W-1:0]         mid_index;
    logic [MID_W-1:0]         pair_first;
    logic [MID_W-1:0]         pair_second;
    logic signed [DATA_W-1:0] mid_value;
    logic [COUNT_W-1:0]       match_count;
    logic                     overflow;
    logic                     last_result;
  } search_result_t;

  logic signed [DATA_W-1:0] elems [MAX_ELEMS];
  int                       fill;
  bit                       dropped;
  search_result_t           expected_results [$];

  function automatic string describe(search_result_t r);
    return $sformatf("kind %0d i %0d j %0d k %0d value %0d count %0d ovf %0d last %0d",
                     r.kind, r.mid_index, r.pair_first, r.pair_second, r.mid_value,
                     r.match_count, r.overflow, r.last_result);
  endfunction

  // Pair search over the loaded elements; sums are exact, never wrapped.
  task automatic search_store();
    search_result_t r;
    longint         twice;
    int             found;
    int             emitted;
    bit             hit;
    found   = 0;
    emitted = 0;
    for (int i = 0; i < fill; i++) begin
      twice = 2 * longint'(elems[i]);
      hit   = 1'b0;
      for (int j = 0; j + 1 < fill && !hit; j++) begin
        if (j == i) continue;
        for (int k = j + 1; k < fill && !hit; k++) begin
          if (k != i && longint'(elems[j]) + longint'(elems[k]) == twice) begin
            hit = 1'b1;
            if (found < COUNT_MAX) found++;
            if (emitted < MAX_ENTRIES) begin
              r             = '0;
              r.kind        = KIND_ENTRY;
              r.mid_index   = MID_W'(i);
              r.pair_first  = MID_W'(j);
              r.pair_second = MID_W'(k);
              r.mid_value   = elems[i];
              r.overflow    = dropped;
              expected_results.push_back(r);
              emitted++;
            end
          end
        end
      end
    end
    r             = '0;
    r.kind        = KIND_TOTAL;
    r.match_count = COUNT_W'(found);
    r.overflow    = dropped;
    r.last_result = 1'b1;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    search_result_t got;
    search_result_t want;
    if (!rst_n) begin
      fill            = 0;
      dropped         = 1'b0;
      fail_count      = 0;
      results_checked = 0;
      entries_checked = 0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.kind        = out_mon.result_kind;
        got.mid_index   = out_mon.mid_index;
        got.pair_first  = out_mon.pair_first;
        got.pair_second = out_mon.pair_second;
        got.mid_value   = out_mon.mid_value;
        got.match_count = out_mon.match_count;
        got.overflow    = out_mon.overflow_flag;
        got.last_result = out_mon.last_result;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: %s", describe(got));
        end else begin
          want = expected_results.pop_front();
          if (want.kind == KIND_ENTRY) entries_checked++;
          results_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d\n  expected %s\n  actual   %s", results_checked,
                       describe(want), describe(got));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (fill < MAX_ELEMS) begin
          elems[fill] = in_mon.elem_value;
          fill++;
        end else begin
          dropped = 1'b1;
        end
        if (in_mon.last_item) begin
          search_store();
          fill    = 0;
          dropped = 1'b0;
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the midpoint_element_search testbench: clock, reset, element runs with random
// gaps on both channels, and the verdict. Depends on mes_pkg, the channel interfaces,
// midpoint_element_search and midpoint_search_checker.

module testbench;
  import mes_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 430;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 20;

  typedef enum int {
    VAL_RANDOM,
    VAL_CLUSTER,
    VAL_PROGRESSION,
    VAL_EXTREME,
    VAL_EQUAL
  } value_mode_t;

  logic clk;
  logic rst_n = 1'b0;

  mes_in_if  in_ch ();
  mes_out_if out_ch ();

  int fail_count;
  int outstanding;
  int results_checked;
  int entries_checked;
  int cycle_count   = 0;
  int runs_sent     = 0;
  int elems_sent    = 0;
  int overflow_runs = 0;
  int results_taken = 0;
  int send_left     = 0;
  int take_left     = 0;
  bit send_calm     = 1'b0;
  bit take_calm     = 1'b0;

  midpoint_element_search dut (
    .clk,
    .rst_n,
    .in_ch,
    .out_ch
  );

  midpoint_search_checker mon (
    .clk,
    .rst_n,
    .in_mon (in_ch),
    .out_mon (out_ch),
    .fail_count,
    .outstanding,
    .results_checked,
    .entries_checked
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("midpoint_element_search: mismatch");
      $finish;
    end
  end

  // Stretches of back-to-back traffic are mixed at random with stretches of random gaps.
  function automatic int next_gap(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(8, 40);
    end
    left--;
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  task automatic send_elem(logic signed [DATA_W-1:0] value, logic is_last);
    int gap;
    gap = next_gap(send_left, send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.elem_value <= value;
    in_ch.last_item  <= is_last;
    in_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    elems_sent++;
  endtask

  task automatic send_run(int n, value_mode_t mode);
    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W-1:0] step;
    logic signed [DATA_W-1:0] v;
    base = $urandom;
    step = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20) - 10;
    for (int t = 0; t < n; t++) begin
      case (mode)
        VAL_CLUSTER:     v = base + $urandom_range(0, 6) - 3;
        VAL_PROGRESSION: v = base + step * t;
        VAL_EXTREME: begin
          case ($urandom_range(0, 6))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = -1;
            3:       v = 0;
            4:       v = 1;
            5:       v = 32'sh8000_0001;
            default: v = 32'sh7fff_fffe;
          endcase
        end
        VAL_EQUAL:       v = base;
        default:         v = $urandom;
      endcase
      send_elem(v, t == n - 1);
    end
    runs_sent++;
    if (n > MAX_ELEMS) overflow_runs++;
  endtask

  // Short runs: single element, pair, simple midpoint, and the 32-bit extremes: runs of equal
  // extremes, and runs where a wrapped sum would give a false match.
  logic signed [DATA_W-1:0] directed_vals [18] = '{
    5,
    3, 7,
    1, 2, 3,
    32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
    -1, 32'sh7fff_ffff, 32'sh7fff_ffff,
    0, 32'sh8000_0000, 32'sh8000_0000
  };
  int directed_lens [7] = '{1, 2, 3, 3, 3, 3, 3};

  initial begin
    int pos;
    int pick;
    int random_runs;
    in_ch.valid      = 1'b0;
    in_ch.elem_value = '0;
    in_ch.last_item  = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        int gap;
        bit held;
        held = 1'b0;
        forever begin
          gap = next_gap(take_left, take_calm);
          if (!held && results_taken >= HOLD_AFTER) begin
            held = 1'b1;
            gap  = LONG_HOLD;
          end
          if (gap > 0) begin
            out_ch.ready <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          out_ch.ready <= 1'b1;
          @(posedge clk);
          while (!out_ch.valid) @(posedge clk);
          results_taken++;
        end
      end
    join_none

    pos = 0;
    foreach (directed_lens[r]) begin
      for (int t = 0; t < directed_lens[r]; t++) begin
        send_elem(directed_vals[pos], t == directed_lens[r] - 1);
        pos++;
      end
      runs_sent++;
    end

    random_runs = 0;
    while (elems_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (random_runs == 0)
        send_run(MAX_ELEMS + 2, VAL_EQUAL);
      else if (random_runs == 1)
        send_run(MAX_ELEMS, VAL_CLUSTER);
      else if (pick < 3)
        send_run(MAX_ELEMS, VAL_EQUAL);
      else if (pick < 7)
        send_run($urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 4),
                 value_mode_t'($urandom_range(0, 3)));
      else if (pick < 12)
        send_run($urandom_range(1, 2), value_mode_t'($urandom_range(0, 4)));
      else if (pick < 30)
        send_run($urandom_range(11, 20), value_mode_t'($urandom_range(0, 4)));
      else
        send_run($urandom_range(3, 10), value_mode_t'($urandom_range(0, 4)));
      random_runs++;
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d runs, %0d elements, %0d of the runs past store capacity.",
             runs_sent, elems_sent, overflow_runs);
    $display("Checked %0d results, %0d of them midpoint entries, %0d failures.",
             results_checked, entries_checked, fail_count);
    if (fail_count == 0)
      $display("midpoint_element_search: match");
    else
      $display("midpoint_element_search: mismatch");
    $finish;
  end

endmodule
